// ----- src/vpsa_pkg.sv -----
// Shared types and constants for the voxel pair similarity accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package vpsa_pkg;

    localparam int NUM_STATS = 16;
    localparam int STAT_W    = 64;
    localparam int NUM_AG    = 11;
    localparam int MASK_W    = 16;
    localparam int PAD_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IDX_W     = 4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTSIDE_BG      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MASK_ENABLE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_PAD_ENABLE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_PAD_VALUE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEST_PAD_ENABLE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEST_PAD_VALUE  = 3'd5;

    // agreement counter slots
    localparam int AG_MATCH     = 0;
    localparam int AG_SUBST     = 1;
    localparam int AG_REJECT    = 2;
    localparam int AG_FG_CNT    = 3;
    localparam int AG_FG_MATCH  = 4;
    localparam int AG_FG_SUBST  = 5;
    localparam int AG_FG_REJECT = 6;
    localparam int AG_M_CNT     = 7;
    localparam int AG_M_MATCH   = 8;
    localparam int AG_M_SUBST   = 9;
    localparam int AG_M_REJECT  = 10;

    // statistic slots in the result stream
    localparam int ST_PAIR    = 0;
    localparam int ST_ABS     = 1;
    localparam int ST_SQ      = 2;
    localparam int ST_PROD    = 3;
    localparam int ST_UNEQUAL = 4;
    localparam int ST_AG_BASE = 5;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

    typedef struct packed {
        logic outside_bg;
        logic mask_enable;
        logic ref_pad_enable;
        logic [PAD_W-1:0] ref_pad_value;
        logic test_pad_enable;
        logic [PAD_W-1:0] test_pad_value;
    } vpsa_cfg_t;

    // per-voxel increment decisions
    typedef struct packed {
        logic              pair;
        logic              sums;
        logic              unequal;
        logic [NUM_AG-1:0] ag;
        logic              last;
    } vpsa_inc_t;

    typedef logic [NUM_STATS-1:0][STAT_W-1:0] vpsa_stats_t;

endpackage

`default_nettype wire

// ----- src/vpsa_eval.sv -----
// Input register and per-voxel evaluation stage: presence, region flags,
// absolute difference, square and product. Depends on vpsa_pkg.
`default_nettype none

module vpsa_eval #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire vpsa_pkg::vpsa_cfg_t           cfg,
    input  wire logic                          in_valid,
    input  wire logic [VALUE_BITS-1:0]         ref_value,
    input  wire logic [VALUE_BITS-1:0]         test_value,
    input  wire logic [vpsa_pkg::MASK_W-1:0]   mask_value,
    input  wire logic                          last_voxel,
    output logic                               b_valid,
    output vpsa_pkg::vpsa_inc_t                b_inc,
    output logic [VALUE_BITS-1:0]              b_abs,
    output logic [2*VALUE_BITS-1:0]            b_sq,
    output logic signed [2*VALUE_BITS-1:0]     b_prod
);
    import vpsa_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int CMP_W = (VB > PAD_W) ? VB + 1 : PAD_W + 1;

    logic                a_valid_reg;
    logic [VB-1:0]       a_ref_reg;
    logic [VB-1:0]       a_test_reg;
    logic [MASK_W-1:0]   a_mask_reg;
    logic                a_last_reg;

    logic                b_valid_reg;
    vpsa_inc_t           b_inc_reg;
    logic [VB-1:0]       b_abs_reg;
    logic [2*VB-1:0]     b_sq_reg;
    logic signed [2*VB-1:0] b_prod_reg;

    logic signed [VB-1:0]    r;
    logic signed [VB-1:0]    t_raw;
    logic signed [VB-1:0]    t;
    logic signed [CMP_W-1:0] r_ext;
    logic signed [CMP_W-1:0] t_ext;
    logic signed [CMP_W-1:0] ref_pad_ext;
    logic signed [CMP_W-1:0] test_pad_ext;
    logic                ref_exist;
    logic                test_raw_exist;
    logic                test_exist;
    logic                both;
    logic                reject;
    logic                eq;
    logic                fg;
    logic                in_region;
    logic signed [VB:0]  diff;
    logic [VB:0]         diff_neg;
    logic [VB-1:0]       abs_diff;
    vpsa_inc_t           inc;

    always_comb begin
        r            = $signed(a_ref_reg);
        t_raw        = $signed(a_test_reg);
        r_ext        = CMP_W'(r);
        t_ext        = CMP_W'(t_raw);
        ref_pad_ext  = CMP_W'($signed(cfg.ref_pad_value));
        test_pad_ext = CMP_W'($signed(cfg.test_pad_value));

        ref_exist      = !(cfg.ref_pad_enable && (r_ext == ref_pad_ext));
        test_raw_exist = !(cfg.test_pad_enable && (t_ext == test_pad_ext));
        // absent test voxel may stand in as a present zero
        test_exist     = test_raw_exist || cfg.outside_bg;
        t              = test_raw_exist ? t_raw : '0;

        both      = ref_exist && test_exist;
        reject    = ref_exist && !test_exist;
        eq        = (r == t);
        fg        = (r != '0);
        in_region = !cfg.mask_enable || (a_mask_reg != '0);

        diff     = (VB+1)'(r) - (VB+1)'(t);
        diff_neg = -diff;
        abs_diff = diff[VB] ? diff_neg[VB-1:0] : diff[VB-1:0];

        inc.pair    = both;
        inc.sums    = both && in_region;
        inc.unequal = (both && !eq) || (!both && (ref_exist || test_exist));
        inc.last    = a_last_reg;
        inc.ag                = '0;
        inc.ag[AG_MATCH]      = both && eq;
        inc.ag[AG_SUBST]      = both && !eq;
        inc.ag[AG_REJECT]     = reject;
        inc.ag[AG_FG_CNT]     = ref_exist && fg;
        inc.ag[AG_FG_MATCH]   = both && eq && fg;
        inc.ag[AG_FG_SUBST]   = both && !eq && fg;
        inc.ag[AG_FG_REJECT]  = reject && fg;
        inc.ag[AG_M_CNT]      = ref_exist && in_region;
        inc.ag[AG_M_MATCH]    = both && eq && in_region;
        inc.ag[AG_M_SUBST]    = both && !eq && in_region;
        inc.ag[AG_M_REJECT]   = reject && in_region;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_ref_reg  <= ref_value;
            a_test_reg <= test_value;
            a_mask_reg <= mask_value;
            a_last_reg <= last_voxel;
            b_inc_reg  <= inc;
            b_abs_reg  <= abs_diff;
            b_sq_reg   <= abs_diff * abs_diff;
            b_prod_reg <= r * t;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_inc   = b_inc_reg;
    assign b_abs   = b_abs_reg;
    assign b_sq    = b_sq_reg;
    assign b_prod  = b_prod_reg;

    // a frozen pipe keeps its evaluated voxel
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance && b_valid_reg) |=> (b_valid_reg && $stable(b_inc_reg)))
        else $error("evaluated voxel changed while stalled");

endmodule

`default_nettype wire

// ----- src/vpsa_accum.sv -----
// Running sums and counters; on the last voxel hands the 16 totals to the
// result buffer and clears. Depends on vpsa_pkg.
`default_nettype none

module vpsa_accum #(
    parameter int VALUE_BITS = 16,
    parameter int MAX_VOXELS = 16777216
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              advance,
    input  wire logic                              b_valid,
    input  wire vpsa_pkg::vpsa_inc_t               b_inc,
    input  wire logic [VALUE_BITS-1:0]             b_abs,
    input  wire logic [2*VALUE_BITS-1:0]           b_sq,
    input  wire logic signed [2*VALUE_BITS-1:0]    b_prod,
    output logic                                   stats_load,
    output vpsa_pkg::vpsa_stats_t                  stats
);
    import vpsa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VOXELS) + 1;
    localparam int ABS_W  = VALUE_BITS + CNT_W;
    localparam int SQ_W   = 2 * VALUE_BITS + CNT_W;
    localparam int PROD_W = 2 * VALUE_BITS - 1 + CNT_W;

    logic [CNT_W-1:0]  pair_count_reg,    pair_count_next;
    logic [ABS_W-1:0]  abs_diff_sum_reg,  abs_diff_sum_next;
    logic [SQ_W-1:0]   sq_diff_sum_reg,   sq_diff_sum_next;
    logic [PROD_W-1:0] product_sum_reg,   product_sum_next;
    logic [CNT_W-1:0]  unequal_count_reg, unequal_count_next;
    logic [CNT_W-1:0]  ag_reg  [NUM_AG];
    logic [CNT_W-1:0]  ag_next [NUM_AG];

    logic take;
    logic [PROD_W-1:0] prod_add;

    assign take     = advance && b_valid;
    assign prod_add = PROD_W'(b_prod);

    always_comb begin
        pair_count_next    = pair_count_reg + CNT_W'(b_inc.pair);
        unequal_count_next = unequal_count_reg + CNT_W'(b_inc.unequal);
        abs_diff_sum_next  = abs_diff_sum_reg;
        sq_diff_sum_next   = sq_diff_sum_reg;
        product_sum_next   = product_sum_reg;
        if (b_inc.sums) begin
            abs_diff_sum_next = abs_diff_sum_reg + ABS_W'(b_abs);
            sq_diff_sum_next  = sq_diff_sum_reg + SQ_W'(b_sq);
            product_sum_next  = product_sum_reg + prod_add;
        end
        for (int k = 0; k < NUM_AG; k++) begin
            ag_next[k] = ag_reg[k] + CNT_W'(b_inc.ag[k]);
        end
    end

    always_comb begin
        stats             = '0;
        stats[ST_PAIR]    = STAT_W'(pair_count_next);
        stats[ST_ABS]     = STAT_W'(abs_diff_sum_next);
        stats[ST_SQ]      = STAT_W'(sq_diff_sum_next);
        stats[ST_PROD]    = STAT_W'($signed(product_sum_next));
        stats[ST_UNEQUAL] = STAT_W'(unequal_count_next);
        for (int k = 0; k < NUM_AG; k++) begin
            stats[ST_AG_BASE + k] = STAT_W'(ag_next[k]);
        end
    end

    assign stats_load = take && b_inc.last;

    always_ff @(posedge aclk) begin
        if (!aresetn || stats_load) begin
            pair_count_reg    <= '0;
            abs_diff_sum_reg  <= '0;
            sq_diff_sum_reg   <= '0;
            product_sum_reg   <= '0;
            unequal_count_reg <= '0;
            for (int k = 0; k < NUM_AG; k++) begin
                ag_reg[k] <= '0;
            end
        end else if (take) begin
            pair_count_reg    <= pair_count_next;
            abs_diff_sum_reg  <= abs_diff_sum_next;
            sq_diff_sum_reg   <= sq_diff_sum_next;
            product_sum_reg   <= product_sum_next;
            unequal_count_reg <= unequal_count_next;
            for (int k = 0; k < NUM_AG; k++) begin
                ag_reg[k] <= ag_next[k];
            end
        end
    end

    // run boundary clears every accumulator; pair, unequal and reject are checked
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        stats_load |=> (pair_count_reg == '0 && unequal_count_reg == '0
                        && ag_reg[AG_REJECT] == '0))
        else $error("accumulators not cleared after last voxel");

    // a counted pair always lands in exactly one of match or subst
    a_pair_split: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> (b_inc.pair == (b_inc.ag[AG_MATCH] || b_inc.ag[AG_SUBST])))
        else $error("pair count out of step with match/subst");

endmodule

`default_nettype wire

// ----- src/vpsa_drain.sv -----
// Result buffer: holds the 16 totals of a run and shifts them out one per
// transaction. Depends on vpsa_pkg.
`default_nettype none

module vpsa_drain (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        stats_load,
    input  wire vpsa_pkg::vpsa_stats_t       stats,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vpsa_pkg::STAT_W-1:0]      m_tdata,
    output logic [vpsa_pkg::IDX_W-1:0]       m_tuser,
    output logic                             m_tlast
);
    import vpsa_pkg::*;

    vpsa_stats_t        snap_reg;
    logic               busy_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               beat;

    assign beat = busy_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (stats_load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (beat) begin
            if (idx_reg == LAST_IDX) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // shift line: the head entry is always the current beat
    always_ff @(posedge aclk) begin
        if (stats_load) begin
            snap_reg <= stats;
        end else if (beat) begin
            for (int k = 0; k < NUM_STATS - 1; k++) begin
                snap_reg[k] <= snap_reg[k+1];
            end
            snap_reg[NUM_STATS-1] <= '0;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = snap_reg[0];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == LAST_IDX);

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        stats_load |-> !busy_reg)
        else $error("totals loaded while previous run still draining");

    a_end_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && idx_reg == LAST_IDX) |=> !busy_reg)
        else $error("result stream continued past final total");

endmodule

`default_nettype wire

// ----- src/voxel_pair_similarity_accumulator.sv -----
// Voxel pair similarity accumulator, top level: config registers, stream ports.
// Last voxel path: input register, evaluation register, result buffer load.
// One voxel per cycle when not held; 16 totals leave one per cycle on m_tready.
// A last voxel reaching the accumulator while the previous run's totals are
// still draining holds the input until the result buffer is empty.
// Reset (aresetn low, synchronous) zeroes config, accumulators and valids.
`default_nettype none

module voxel_pair_similarity_accumulator #(
    parameter int MAX_VOXELS = 16777216,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [vpsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [vpsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // ref_value, test_value, mask_value, zero fill
    input  wire logic [((2*VALUE_BITS+vpsa_pkg::MASK_W+7)/8)*8-1:0] s_tdata,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // stat_value
    output logic [vpsa_pkg::STAT_W-1:0]              m_tdata,
    // stat_index
    output logic [vpsa_pkg::IDX_W-1:0]               m_tuser,
    output logic                                     m_tlast
);
    import vpsa_pkg::*;

    localparam int VB = VALUE_BITS;

    vpsa_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_OUTSIDE_BG:      cfg_reg.outside_bg      <= cfg_wdata[0];
                CFG_MASK_ENABLE:     cfg_reg.mask_enable     <= cfg_wdata[0];
                CFG_REF_PAD_ENABLE:  cfg_reg.ref_pad_enable  <= cfg_wdata[0];
                CFG_REF_PAD_VALUE:   cfg_reg.ref_pad_value   <= cfg_wdata[PAD_W-1:0];
                CFG_TEST_PAD_ENABLE: cfg_reg.test_pad_enable <= cfg_wdata[0];
                CFG_TEST_PAD_VALUE:  cfg_reg.test_pad_value  <= cfg_wdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic                  advance;
    logic                  b_valid;
    vpsa_inc_t             b_inc;
    logic [VB-1:0]         b_abs;
    logic [2*VB-1:0]       b_sq;
    logic signed [2*VB-1:0] b_prod;
    logic                  stats_load;
    vpsa_stats_t           stats;

    // hold the pipe only when a run end meets a full result buffer
    assign advance  = !(b_valid && b_inc.last && m_tvalid);
    assign s_tready = advance;

    vpsa_eval #(
        .VALUE_BITS (VALUE_BITS)
    ) u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .ref_value  (s_tdata[VB-1:0]),
        .test_value (s_tdata[2*VB-1:VB]),
        .mask_value (s_tdata[2*VB+MASK_W-1:2*VB]),
        .last_voxel (s_tlast),
        .b_valid    (b_valid),
        .b_inc      (b_inc),
        .b_abs      (b_abs),
        .b_sq       (b_sq),
        .b_prod     (b_prod)
    );

    vpsa_accum #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_VOXELS (MAX_VOXELS)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .b_valid    (b_valid),
        .b_inc      (b_inc),
        .b_abs      (b_abs),
        .b_sq       (b_sq),
        .b_prod     (b_prod),
        .stats_load (stats_load),
        .stats      (stats)
    );

    vpsa_drain u_drain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stats_load (stats_load),
        .stats      (stats),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
